>>> rtl/pip_pkg.sv
// Shared constants and word types for the point-in-polygon tester.
package pip_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_BITS   = 12;
    localparam int ADDR_BITS    = $clog2(MAX_VERTICES);
    localparam int CNT_BITS     = $clog2(MAX_VERTICES + 1);
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int PROD_BITS    = 2 * DIFF_BITS;
    localparam int VTX_BITS     = 2 * COORD_BITS;
    localparam int XING_BITS    = 6;

    localparam logic [XING_BITS-1:0] CROSS_SAT = '1;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    typedef struct packed {
        logic [1:0]            operation;
        logic [COORD_BITS-1:0] coord_x;
        logic [COORD_BITS-1:0] coord_y;
    } in_word_t;

    typedef struct packed {
        logic                 inside_res;
        logic [XING_BITS-1:0] crossings;
        logic                 overflowed;
    } out_word_t;

endpackage

>>> rtl/pip_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/point_in_polygon_test_top.sv
// Top level of the point-in-polygon tester: vertex memory, edge pipeline and control.
//
// Clear and append words give no result. A query word with at least two vertices stored
// makes one vertex-memory read per vertex, then passes two pipeline stages for the
// cross-multiply and the count, and busy stays high meanwhile; with fewer vertices it
// is answered without busy. Each query result is shown for one cycle with done high
// and must be taken then.
module point_in_polygon_test_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  pip_pkg::in_word_t  cmd,
    output logic               done,
    output pip_pkg::out_word_t result
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                                   state_reg, state_next;
    logic [pip_pkg::CNT_BITS-1:0]           count_reg, count_next;
    logic                                   drop_reg, drop_next;
    logic [pip_pkg::CNT_BITS-1:0]           rd_idx_reg, rd_idx_next;
    logic                                   issued_reg, issued_next;
    logic                                   dat_v_reg, dat_first_reg, dat_last_reg;
    logic                                   e_v_reg, e_last_reg;
    logic [pip_pkg::CNT_BITS-1:0]           xing_reg, xing_next;
    logic                                   done_reg, done_next;
    pip_pkg::out_word_t                     result_reg, result_next;

    logic [pip_pkg::COORD_BITS-1:0]         px_reg, py_reg;
    logic [pip_pkg::VTX_BITS-1:0]           prev_reg;
    logic signed [pip_pkg::PROD_BITS-1:0]   lhs_reg, rhs_reg;
    logic                                   vert_hit_reg, oblique_reg, dy_pos_reg;

    logic                                   accept, issuing, last_issue, we;
    logic [pip_pkg::VTX_BITS-1:0]           rdata;
    logic [pip_pkg::ADDR_BITS-1:0]          raddr;
    logic [pip_pkg::COORD_BITS-1:0]         x0, y0, x1, y1, ylo, yhi;
    logic signed [pip_pkg::DIFF_BITS-1:0]   dx, dy, qy, qx;
    logic signed [pip_pkg::PROD_BITS-1:0]   lhs, rhs;
    logic                                   edge_v, hit;

    assign accept     = start && (state_reg == ST_IDLE);
    assign issuing    = (state_reg == ST_RUN) && !issued_reg;
    assign last_issue = rd_idx_reg == (count_reg - pip_pkg::CNT_BITS'(1));
    assign raddr      = rd_idx_reg[pip_pkg::ADDR_BITS-1:0];
    assign we         = accept && (cmd.operation == pip_pkg::OP_APPEND)
                        && (count_reg < pip_pkg::CNT_BITS'(pip_pkg::MAX_VERTICES));

    pip_ram #(
        .WIDTH (pip_pkg::VTX_BITS),
        .DEPTH (pip_pkg::MAX_VERTICES)
    ) u_vtx_ram (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[pip_pkg::ADDR_BITS-1:0]),
        .wdata ({cmd.coord_x, cmd.coord_y}),
        .raddr (raddr),
        .rdata (rdata)
    );

    // edge classification and cross-multiply
    always_comb
    begin
        edge_v = dat_v_reg && !dat_first_reg;
        x0     = prev_reg[pip_pkg::VTX_BITS-1:pip_pkg::COORD_BITS];
        y0     = prev_reg[pip_pkg::COORD_BITS-1:0];
        x1     = rdata[pip_pkg::VTX_BITS-1:pip_pkg::COORD_BITS];
        y1     = rdata[pip_pkg::COORD_BITS-1:0];
        ylo    = (y0 < y1) ? y0 : y1;
        yhi    = (y0 < y1) ? y1 : y0;
        dx     = $signed({1'b0, x1}) - $signed({1'b0, x0});
        dy     = $signed({1'b0, y1}) - $signed({1'b0, y0});
        qy     = $signed({1'b0, py_reg}) - $signed({1'b0, y0});
        qx     = $signed({1'b0, px_reg}) - $signed({1'b0, x0});
        lhs    = pip_pkg::PROD_BITS'(qy) * pip_pkg::PROD_BITS'(dx);
        rhs    = pip_pkg::PROD_BITS'(qx) * pip_pkg::PROD_BITS'(dy);
    end

    assign hit = vert_hit_reg
                 || (oblique_reg && (dy_pos_reg ? (lhs_reg > rhs_reg) : (lhs_reg < rhs_reg)));

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        drop_next   = drop_reg;
        rd_idx_next = rd_idx_reg;
        issued_next = issued_reg;
        xing_next   = xing_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.operation)
                        pip_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                            drop_next  = 1'b0;
                        end
                        pip_pkg::OP_APPEND:
                        begin
                            if (we)
                                count_next = count_reg + pip_pkg::CNT_BITS'(1);
                            else
                                drop_next = 1'b1;
                        end
                        pip_pkg::OP_QUERY:
                        begin
                            if (count_reg < pip_pkg::CNT_BITS'(2))
                            begin
                                done_next              = 1'b1;
                                result_next.inside_res = 1'b0;
                                result_next.crossings  = '0;
                                result_next.overflowed = drop_reg;
                            end
                            else
                            begin
                                state_next  = ST_RUN;
                                rd_idx_next = '0;
                                issued_next = 1'b0;
                                xing_next   = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                if (issuing)
                begin
                    if (last_issue)
                        issued_next = 1'b1;
                    else
                        rd_idx_next = rd_idx_reg + pip_pkg::CNT_BITS'(1);
                end
                if (e_v_reg)
                begin
                    xing_next = xing_reg + pip_pkg::CNT_BITS'(hit);
                    if (e_last_reg)
                    begin
                        state_next             = ST_IDLE;
                        done_next              = 1'b1;
                        result_next.inside_res = xing_next[0];
                        result_next.crossings  =
                            (xing_next > pip_pkg::CNT_BITS'(pip_pkg::CROSS_SAT))
                            ? pip_pkg::CROSS_SAT : xing_next[pip_pkg::XING_BITS-1:0];
                        result_next.overflowed = drop_reg;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            rd_idx_reg    <= '0;
            issued_reg    <= 1'b1;
            xing_reg      <= '0;
            done_reg      <= 1'b0;
            dat_v_reg     <= 1'b0;
            dat_first_reg <= 1'b0;
            dat_last_reg  <= 1'b0;
            e_v_reg       <= 1'b0;
            e_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            rd_idx_reg    <= rd_idx_next;
            issued_reg    <= issued_next;
            xing_reg      <= xing_next;
            done_reg      <= done_next;
            dat_v_reg     <= issuing;
            dat_first_reg <= issuing && (rd_idx_reg == '0);
            dat_last_reg  <= issuing && last_issue;
            e_v_reg       <= edge_v;
            e_last_reg    <= edge_v && dat_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (accept)
        begin
            px_reg <= cmd.coord_x;
            py_reg <= cmd.coord_y;
        end
        if (dat_v_reg)
            prev_reg <= rdata;
        vert_hit_reg <= (x0 == x1) && (py_reg >= ylo) && (py_reg <= yhi) && (px_reg < x0);
        oblique_reg  <= (x0 != x1) && (y0 != y1) && (py_reg > ylo) && (py_reg < yhi);
        dy_pos_reg   <= y1 > y0;
        lhs_reg      <= lhs;
        rhs_reg      <= rhs;
    end

    assign busy   = state_reg == ST_RUN;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> rtl/pip_checker.sv
// Port-level assertions for the point-in-polygon tester, bound to the top level.
module pip_port_checks (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input pip_pkg::in_word_t  cmd,
    input logic               done,
    input pip_pkg::out_word_t result
);

    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy)
                  || $past(start && !busy && cmd.operation == pip_pkg::OP_QUERY)))
        else $error("result word without a query behind it");

    a_query_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.operation == pip_pkg::OP_QUERY) |=> (busy || done))
        else $error("query word neither ran nor answered");

    a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !(start && cmd.operation == pip_pkg::OP_QUERY)) |=> !done)
        else $error("result word after a non-query word");

    a_parity: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.crossings != pip_pkg::CROSS_SAT)
        |-> (result.inside_res == result.crossings[0]))
        else $error("inside flag disagrees with crossing count");

endmodule

bind point_in_polygon_test_top pip_port_checks u_pip_port_checks (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
);
